FILE: hdl/dv2a_pkg.sv
// package for the direction vector to angles pipeline
// angle table, fixed widths and the binary angle to degrees conversion
package dv2a_pkg;

    localparam int CORDIC_W = 36;
    localparam int STEPS    = 32;

    typedef logic [31:0] t_bam;
    typedef logic [24:0] t_deg;
    typedef logic signed [CORDIC_W-1:0] t_cval;

    localparam t_bam HALF_TURN_BAM  = 32'h8000_0000;
    localparam t_deg DEG_FULL_Q     = 25'(360 * 65536);
    localparam t_deg DEG_PITCH_UP   = 25'(270 * 65536);
    localparam t_deg DEG_PITCH_DOWN = 25'(90 * 65536);

    function automatic t_bam atan_bam(input logic [4:0] idx);
        t_bam v;
        unique case (idx)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    // acc * 360 with round half up, full turn wraps to zero
    function automatic t_deg bam_to_deg(input t_bam acc);
        logic [40:0] w;
        logic [40:0] p;
        t_deg t;
        w = {9'b0, acc};
        p = (w << 8) + (w << 6) + (w << 5) + (w << 3) + 41'd32768;
        t = p[40:16];
        if (t >= DEG_FULL_Q) begin
            t = '0;
        end
        return t;
    endfunction

endpackage

FILE: hdl/dv2a_sqrt_stage.sv
// one bit of the pipelined integer square root
// depends on nothing outside this file
module dv2a_sqrt_stage #(
    parameter int BIT = 31
) (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [63:0] i_rem,
    input  logic [31:0] i_root,
    output logic [63:0] o_rem,
    output logic [31:0] o_root
);
    logic [65:0] trial;
    logic [63:0] n_rem;
    logic [31:0] n_root;
    logic [63:0] r_rem;
    logic [31:0] r_root;

    always_comb begin
        trial = ({34'b0, i_root} << (BIT + 1)) + (66'd1 << (2 * BIT));
        if ({2'b0, i_rem} >= trial) begin
            n_rem  = i_rem - trial[63:0];
            n_root = i_root | (32'd1 << BIT);
        end else begin
            n_rem  = i_rem;
            n_root = i_root;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
endmodule

FILE: hdl/dv2a_cordic_stage.sv
// one vectoring iteration of the cordic with a carried side word
// depends on dv2a_pkg for the angle table and widths
module dv2a_cordic_stage
    import dv2a_pkg::*;
#(
    parameter int STEP = 0,
    parameter int SB_W = 1
) (
    input  logic            i_clk,
    input  logic            i_en,
    input  t_cval           i_a,
    input  t_cval           i_b,
    input  t_bam            i_acc,
    input  logic [SB_W-1:0] i_sb,
    output t_cval           o_a,
    output t_cval           o_b,
    output t_bam            o_acc,
    output logic [SB_W-1:0] o_sb
);
    t_cval           n_a, n_b, r_a, r_b;
    t_bam            n_acc, r_acc;
    logic [SB_W-1:0] r_sb;
    t_cval           da, db;

    always_comb begin
        da = i_a >>> STEP;
        db = i_b >>> STEP;
        if (!i_b[CORDIC_W-1]) begin
            n_a   = i_a + db;
            n_b   = i_b - da;
            n_acc = i_acc + atan_bam(5'(STEP));
        end else begin
            n_a   = i_a - db;
            n_b   = i_b + da;
            n_acc = i_acc - atan_bam(5'(STEP));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= n_a;
            r_b   <= n_b;
            r_acc <= n_acc;
            r_sb  <= i_sb;
        end
    end

    assign o_a   = r_a;
    assign o_b   = r_b;
    assign o_acc = r_acc;
    assign o_sb  = r_sb;
endmodule

FILE: hdl/direction_vector_to_angles_top.sv
// throughput: one vector per cycle unless stalled at the output, set by the
// 32 stage sqrt/yaw cordic section followed by the 32 stage pitch cordic, all
// advancing on one shared enable
// reset: synchronous active low, clears the valid bits only
// depends on dv2a_pkg, dv2a_sqrt_stage and dv2a_cordic_stage
module direction_vector_to_angles_top
    import dv2a_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,  // vec_x, vec_y, vec_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata   // pitch_deg, yaw_deg, zero fill
);
    localparam int NVLD = STEPS * 2 + 3;
    localparam int YSB  = CORDIC_W + 2;
    localparam int PSB  = 32 + 2;

    logic            en;
    logic [NVLD-1:0] r_vld;

    logic signed [31:0] vx, vy, vz;
    logic [31:0] mx, my;

    logic signed [31:0] r_x, r_y, r_z;
    logic [63:0] r_sqx, r_sqy;
    logic [63:0] r_sum;
    t_cval r_ya0, r_yb0, r_nz;
    t_bam  r_yacc0;
    logic  r_zero, r_zpos, r_zero1;

    logic [63:0] sq_rem  [0:STEPS];
    logic [31:0] sq_root [0:STEPS];
    t_cval ya [0:STEPS];
    t_cval yb [0:STEPS];
    t_bam  yacc [0:STEPS];
    logic [YSB-1:0] ysb [0:STEPS];
    t_cval pa [0:STEPS];
    t_cval pb [0:STEPS];
    t_bam  pacc [0:STEPS];
    logic [PSB-1:0] psb [0:STEPS];

    t_deg n_pitch, n_yaw;
    t_deg r_pitch, r_yaw;

    assign en         = !r_vld[NVLD-1] || i_m_tready;
    assign o_s_tready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NVLD-2:0], i_s_tvalid};
        end
    end

    assign vx = i_s_tdata[31:0];
    assign vy = i_s_tdata[63:32];
    assign vz = i_s_tdata[95:64];
    assign mx = vx[31] ? (~vx + 32'd1) : vx;
    assign my = vy[31] ? (~vy + 32'd1) : vy;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sqx   <= 64'(mx) * 64'(mx);
            r_sqy   <= 64'(my) * 64'(my);
            r_x     <= vx;
            r_y     <= vy;
            r_z     <= vz;
            r_zero1 <= (vx == '0) && (vy == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum  <= r_sqx + r_sqy;
            r_ya0  <= r_x[31] ? -CORDIC_W'(r_x) : CORDIC_W'(r_x);
            r_yb0  <= r_x[31] ? -CORDIC_W'(r_y) : CORDIC_W'(r_y);
            r_yacc0 <= r_x[31] ? HALF_TURN_BAM : '0;
            r_nz   <= -CORDIC_W'(r_z);
            r_zero <= r_zero1;
            r_zpos <= !r_z[31] && (r_z != '0);
        end
    end

    assign sq_rem[0]  = r_sum;
    assign sq_root[0] = '0;
    assign ya[0]      = r_ya0;
    assign yb[0]      = r_yb0;
    assign yacc[0]    = r_yacc0;
    assign ysb[0]     = {r_nz, r_zero, r_zpos};

    for (genvar k = 0; k < STEPS; k++) begin : g_first
        dv2a_sqrt_stage #(.BIT(STEPS - 1 - k)) u_sqrt (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_rem  (sq_rem[k]),
            .i_root (sq_root[k]),
            .o_rem  (sq_rem[k+1]),
            .o_root (sq_root[k+1])
        );
        dv2a_cordic_stage #(.STEP(k), .SB_W(YSB)) u_yaw (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (ya[k]),
            .i_b   (yb[k]),
            .i_acc (yacc[k]),
            .i_sb  (ysb[k]),
            .o_a   (ya[k+1]),
            .o_b   (yb[k+1]),
            .o_acc (yacc[k+1]),
            .o_sb  (ysb[k+1])
        );
    end

    assign pa[0]   = CORDIC_W'(sq_root[STEPS]);
    assign pb[0]   = ysb[STEPS][YSB-1:2];
    assign pacc[0] = '0;
    assign psb[0]  = {yacc[STEPS], ysb[STEPS][1:0]};

    for (genvar k = 0; k < STEPS; k++) begin : g_pitch
        dv2a_cordic_stage #(.STEP(k), .SB_W(PSB)) u_pitch (
            .i_clk (i_clk),
            .i_en  (en),
            .i_a   (pa[k]),
            .i_b   (pb[k]),
            .i_acc (pacc[k]),
            .i_sb  (psb[k]),
            .o_a   (pa[k+1]),
            .o_b   (pb[k+1]),
            .o_acc (pacc[k+1]),
            .o_sb  (psb[k+1])
        );
    end

    always_comb begin
        if (psb[STEPS][1]) begin
            n_yaw   = '0;
            n_pitch = psb[STEPS][0] ? DEG_PITCH_UP : DEG_PITCH_DOWN;
        end else begin
            n_yaw   = bam_to_deg(psb[STEPS][PSB-1:2]);
            n_pitch = bam_to_deg(pacc[STEPS]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pitch <= n_pitch;
            r_yaw   <= n_yaw;
        end
    end

    assign o_m_tvalid = r_vld[NVLD-1];
    assign o_m_tdata  = {6'b0, r_yaw, r_pitch};
endmodule

FILE: hdl/dv2a_checker.sv
// port level checks for the direction vector to angles top level
// bound to direction_vector_to_angles_top, depends on dv2a_pkg
module dv2a_checker
    import dv2a_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [55:0] o_m_tdata
);
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid)
        else $error("result transaction dropped while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[24:0] < DEG_FULL_Q) && (o_m_tdata[49:25] < DEG_FULL_Q))
        else $error("angle out of range");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");
endmodule

bind direction_vector_to_angles_top dv2a_checker u_dv2a_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: bench/testbench.sv
// testbench for direction_vector_to_angles_top: random and directed vectors
// checked against an in-bench cordic model of pitch and yaw; needs dv2a_pkg
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import dv2a_pkg::*;

    typedef struct packed {
        t_deg pitch;
        t_deg yaw;
    } t_angles;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [95:0] i_s_tdata = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [55:0] o_m_tdata;

    t_angles angle_queue[$];
    int      mismatches = 0;
    int      sent = 0;
    int      received = 0;
    int      cycles = 0;
    bit      no_idle = 1'b0;
    int      hold_off = 0;

    localparam int CYCLE_LIMIT = 400000;

    direction_vector_to_angles_top u_top (
        .i_clk, .i_rst_n, .i_s_tvalid, .o_s_tready, .i_s_tdata,
        .o_m_tvalid, .i_m_tready, .o_m_tdata
    );

    always #6 i_clk = ~i_clk;

    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] vector_angle(input longint a, input longint b);
        logic [31:0] acc;
        longint da, db;
        acc = 0;
        if (a < 0) begin
            a = -a;
            b = -b;
            acc = 32'h8000_0000;
        end
        for (int i = 0; i < 32; i++) begin
            da = b >>> i;
            db = a >>> i;
            if (b >= 0) begin
                a = a + da;
                b = b - db;
                acc = acc + ATAN_TAB[i];
            end else begin
                a = a - da;
                b = b + db;
                acc = acc - ATAN_TAB[i];
            end
        end
        return acc;
    endfunction

    function automatic t_deg angle_to_deg(input logic [31:0] acc);
        logic [63:0] t;
        t = ({32'd0, acc} * 64'd360 + 64'd32768) >> 16;
        if (t >= (64'd360 << 16)) t = 0;
        return t_deg'(t);
    endfunction

    function automatic t_angles predict_angles(input logic [31:0] xr, yr, zr);
        t_angles r;
        longint x, y, z;
        logic [63:0] mx, my, rad;
        x = longint'($signed(xr));
        y = longint'($signed(yr));
        z = longint'($signed(zr));
        if (x == 0 && y == 0) begin
            r.yaw = '0;
            r.pitch = (z > 0) ? t_deg'(270 * 65536) : t_deg'(90 * 65536);
        end else begin
            mx = (x < 0) ? -x : x;
            my = (y < 0) ? -y : y;
            rad = int_sqrt(mx * mx + my * my);
            r.yaw = angle_to_deg(vector_angle(x, y));
            r.pitch = angle_to_deg(vector_angle(longint'(rad), -z));
        end
        return r;
    endfunction

    function automatic bit idle_now();
        return !no_idle && ($urandom_range(99) < 26);
    endfunction

    task automatic send_vector(input logic [31:0] x, y, z);
        while (idle_now()) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {z, y, x};
        angle_queue.push_back(predict_angles(x, y, z));
        do @(posedge i_clk); while (!o_s_tready);
        sent++;
    endtask

    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !idle_now();
        end
    end

    always @(posedge i_clk) begin
        t_angles got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.pitch = o_m_tdata[24:0];
            got.yaw = o_m_tdata[49:25];
            received++;
            if (angle_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transaction %h", o_m_tdata);
            end else begin
                want = angle_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: pitch %h/%h yaw %h/%h (expected/actual)",
                                 want.pitch, got.pitch, want.yaw, got.yaw);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic logic [31:0] rand_comp();
        case ($urandom_range(5))
            0: return 32'h0;
            1: return 32'($urandom_range(200)) - 32'd100;
            2: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            3: return 32'($signed($urandom) >>> $urandom_range(31));
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        logic [31:0] ext[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h0001_0000};
        send_vector(0, 0, 32'h0001_0000);
        send_vector(0, 0, 0);
        send_vector(0, 0, 32'hFFFF_0000);
        send_vector(0, 0, 32'h8000_0000);
        send_vector(0, 0, 32'h7FFF_FFFF);
        send_vector(32'hFFFF_0000, 32'hFFFF_FFFF, 0);
        send_vector(32'hFFFF_0000, 0, 0);
        send_vector(32'h0001_0000, 32'hFFFF_FFFF, 1);
        for (int i = 0; i < 6; i++)
            send_vector(ext[i], ext[5 - i], ext[(i + 2) % 6]);
        send_vector(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_vector(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_vector(rand_comp(), rand_comp(), rand_comp());
    endtask

    task automatic test_no_idle(input int n);
        no_idle = 1'b1;
        test_random(n);
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_off = 300;
        test_random(150);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(900);
        test_no_idle(300);
        test_backpressure();
        test_random(580);
        drain();
        $display("covered %0d vectors with %0d results: zero plane, extremes, stalls",
                 sent, received);
        if (mismatches == 0 && angle_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule

FILE: direction_vector_to_angles_top.f
hdl/dv2a_pkg.sv
hdl/dv2a_sqrt_stage.sv
hdl/dv2a_cordic_stage.sv
hdl/direction_vector_to_angles_top.sv
hdl/dv2a_checker.sv
bench/testbench.sv
